FILE: sv/ppu_pkg.sv
// Shared types and constants for the particle pool.
`default_nettype none
package ppu_pkg;
   localparam int PoolSizeDefault = 32;
   localparam int PosW  = 24;
   localparam int TimeW = 16;
   localparam int StepW = 12;
   localparam int SlotW = 5;
   localparam logic [StepW-1:0] StepReset = 12'd68;
   localparam logic [PosW-1:0] PosMax = 24'h7FFFFF;
   localparam logic [PosW-1:0] PosMin = 24'h800000;

   typedef enum logic {
      KIND_EMIT = 1'b0,
      KIND_TICK = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic signed [PosW-1:0] pos_x;
      logic signed [PosW-1:0] pos_y;
      logic signed [PosW-1:0] vel_x;
      logic signed [PosW-1:0] vel_y;
      logic [TimeW-1:0]       life_in;
      logic [TimeW-1:0]       size_in;
   } req_type;

   typedef struct packed {
      logic [SlotW-1:0]       slot;
      logic                   accepted;
      logic                   alive;
      logic signed [PosW-1:0] x_out;
      logic signed [PosW-1:0] y_out;
      logic [7:0]             alpha;
      logic [TimeW-1:0]       size_out;
      logic                   last;
   } rsp_type;

   // Saturating add of a 24-bit position and a wider delta.
   function automatic logic [PosW-1:0] sat_pos(input logic signed [PosW-1:0] p,
                                               input logic signed [27:0] d);
      logic signed [28:0] s;
      begin
         s = 29'(signed'(p)) + 29'(d);
         if (s > 29'sd8388607) sat_pos = PosMax;
         else if (s < -29'sd8388608) sat_pos = PosMin;
         else sat_pos = s[PosW-1:0];
      end
   endfunction
endpackage
`default_nettype wire

FILE: sv/ppu_if.sv
// Valid/ready channel interfaces.
`default_nettype none
interface ppu_req_if;
   import ppu_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface ppu_rsp_if;
   import ppu_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface ppu_csr_if;
   import ppu_pkg::*;
   logic             valid;
   logic             ready;
   logic [StepW-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/ppu_ram.sv
// Generic single-port-write, single-read RAM with registered read.
`default_nettype none
module ppu_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: sv/ppu_front.sv
// Front end: request queue of two entries.
`default_nettype none
module ppu_front import ppu_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   ppu_req_if.sink      req,
   output logic         q_valid,
   output req_type      q_data,
   input  wire logic    q_pop
);
   req_type    buf_ff [2];
   logic       wp_ff, rp_ff, wp_in, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign req.ready = (cnt_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_data    = buf_ff[rp_ff];
   assign wp_in     = push ? ~wp_ff : wp_ff;
   assign rp_in     = q_pop ? ~rp_ff : rp_ff;
   assign cnt_in    = cnt_ff + {1'b0, push} - {1'b0, q_pop};

   always_ff @(posedge clock) begin
      if (push) buf_ff[wp_ff] <= req.data;
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count overflow");
   a_pop: assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("pop from empty queue");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop && cnt_ff == 2'd1) |=> cnt_ff == 2'd2)
      else $error("queue count lost");
endmodule
`default_nettype wire

FILE: sv/ppu_back.sv
// Back end: slot sequencer, particle stores and update datapath.
`default_nettype none
module ppu_back import ppu_pkg::*; #(
   parameter int PoolSize = PoolSizeDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [StepW-1:0] step,
   input  wire logic             q_valid,
   input  wire req_type          q_data,
   output logic                  q_pop,
   ppu_rsp_if.source             rsp
);
   localparam int IdxW = (PoolSize > 1) ? $clog2(PoolSize) : 1;
   localparam int RamD = (PoolSize > 1) ? PoolSize : 2;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_READ = 5'b00010,
      ST_MUL  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type          st_ff, st_in;
   logic [PoolSize-1:0] act_ff, act_in;
   logic [IdxW-1:0]    idx_ff, idx_in;
   logic               emit_ff, emit_in;
   rsp_type            out_ff, out_in;
   logic               ov_ff, ov_in;

   logic               wr_en;
   logic [IdxW-1:0]    wr_idx;
   logic [IdxW-1:0]    free_idx;
   logic               free_any;
   logic [95:0]        pv_rd, pv_wd;
   logic [48:0]        lf_rd, lf_wd;
   logic [15:0]        sc_rd, sc_wd;

   logic signed [35:0] mx_ff, my_ff, mx_in, my_in;
   logic signed [16:0] nl_ff, nl_in;
   logic [15:0]        ns_ff, ns_in;
   logic [PosW-1:0]    nx_ff, ny_ff, nx_in, ny_in;
   logic [23:0]        num_ff, num_in;
   logic [15:0]        den_ff;
   logic [7:0]         q_ff, q_in;
   logic [3:0]         dc_ff, dc_in;
   logic [StepW-1:0]   step_tenth;

   ppu_ram #(.Width(96), .Depth(RamD)) u_pv (
      .clock, .wr_en, .wr_addr(wr_idx), .wr_data(pv_wd), .rd_addr(idx_in), .rd_data(pv_rd));
   ppu_ram #(.Width(49), .Depth(RamD)) u_lf (
      .clock, .wr_en, .wr_addr(wr_idx), .wr_data(lf_wd), .rd_addr(idx_in), .rd_data(lf_rd));
   ppu_ram #(.Width(16), .Depth(RamD)) u_sc (
      .clock, .wr_en, .wr_addr(wr_idx), .wr_data(sc_wd), .rd_addr(idx_in), .rd_data(sc_rd));

   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = PoolSize - 1; i >= 0; i--) begin
         if (!act_ff[i]) begin
            free_any = 1'b1;
            free_idx = IdxW'(i);
         end
      end
   end

   // floor(step / 10) by reciprocal multiply, exact for 12-bit steps
   assign step_tenth = StepW'((24'(step) * 24'd3277) >> 15);
   assign rsp.valid = ov_ff;
   assign rsp.data  = out_ff;

   always_comb begin
      st_in   = st_ff;
      act_in  = act_ff;
      idx_in  = idx_ff;
      emit_in = emit_ff;
      out_in  = out_ff;
      ov_in   = ov_ff;
      q_pop   = 1'b0;
      wr_en   = 1'b0;
      wr_idx  = idx_ff;
      pv_wd   = {nx_ff, ny_ff, pv_rd[47:0]};
      lf_wd   = {nl_ff, lf_rd[31:0]};
      sc_wd   = ns_ff;
      mx_in   = signed'(pv_rd[47:24]) * signed'({1'b0, step});
      my_in   = signed'(pv_rd[23:0]) * signed'({1'b0, step});
      nl_in   = signed'(lf_rd[48:32]) - signed'({5'd0, step});
      ns_in   = (17'(sc_rd) + 17'(step_tenth) > 17'd65535) ? 16'hFFFF :
                sc_rd + 16'(step_tenth);
      nx_in   = sat_pos(signed'(pv_rd[95:72]), 28'(mx_ff >>> 12));
      ny_in   = sat_pos(signed'(pv_rd[71:48]), 28'(my_ff >>> 12));
      num_in  = num_ff;
      q_in    = q_ff;
      dc_in   = dc_ff;
      if (ov_ff && rsp.ready) ov_in = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (q_valid && !ov_in) begin
               q_pop = 1'b1;
               if (q_data.kind == KIND_EMIT) begin
                  wr_en  = free_any;
                  wr_idx = free_idx;
                  idx_in = free_idx;
                  pv_wd  = {q_data.pos_x, q_data.pos_y, q_data.vel_x, q_data.vel_y};
                  lf_wd  = {1'b0, q_data.life_in, 16'd0, q_data.life_in};
                  sc_wd  = q_data.size_in;
                  if (free_any) act_in[free_idx] = 1'b1;
                  out_in = '0;
                  out_in.slot     = SlotW'(free_idx);
                  out_in.accepted = free_any;
                  out_in.alive    = free_any;
                  out_in.x_out    = free_any ? q_data.pos_x : '0;
                  out_in.y_out    = free_any ? q_data.pos_y : '0;
                  out_in.alpha    = (free_any && q_data.life_in != 0) ? 8'd255 : 8'd0;
                  out_in.size_out = free_any ? q_data.size_in : '0;
                  out_in.last     = 1'b1;
                  ov_in  = 1'b1;
               end else begin
                  idx_in = '0;
                  st_in  = ST_READ;
               end
            end
         end
         ST_READ: st_in = ST_MUL;
         ST_MUL:  st_in = ST_DIV;
         ST_DIV: begin
            if (dc_ff == 4'd0) begin
               num_in = (nl_ff > 0) ? 24'(unsigned'(nl_ff[15:0])) * 24'd255 : 24'd0;
               q_in   = '0;
            end else if (num_ff >= 24'(den_ff) << (dc_ff - 4'd1)) begin
               num_in = num_ff - (24'(den_ff) << (dc_ff - 4'd1));
               q_in   = q_ff | (8'd1 << (dc_ff - 4'd1));
            end
            dc_in = (dc_ff == 4'd0) ? 4'd8 : dc_ff - 4'd1;
            if (dc_ff == 4'd1) st_in = ST_OUT;
         end
         ST_OUT: begin
            if (!ov_in) begin
               out_in = '0;
               out_in.slot = SlotW'(idx_ff);
               out_in.last = (idx_ff == IdxW'(PoolSize - 1));
               if (act_ff[idx_ff]) begin
                  wr_en = 1'b1;
                  out_in.alive    = (nl_ff > 0);
                  out_in.x_out    = nx_ff;
                  out_in.y_out    = ny_ff;
                  out_in.size_out = ns_ff;
                  out_in.alpha    = (nl_ff > 0) ? q_ff : 8'd0;
                  act_in[idx_ff]  = (nl_ff > 0);
               end
               ov_in = 1'b1;
               if (idx_ff == IdxW'(PoolSize - 1)) st_in = ST_IDLE;
               else begin
                  idx_in = idx_ff + 1'b1;
                  st_in  = ST_READ;
               end
            end
         end
         default: st_in = ST_IDLE;
      endcase
      emit_in = (st_in == ST_IDLE);
   end

   always_ff @(posedge clock) begin
      mx_ff  <= mx_in;
      my_ff  <= my_in;
      if (st_ff == ST_READ) begin
         nl_ff <= nl_in;
         ns_ff <= ns_in;
      end
      if (st_ff == ST_MUL) begin
         nx_ff  <= nx_in;
         ny_ff  <= ny_in;
         den_ff <= lf_rd[15:0];
      end
      num_ff <= num_in;
      q_ff   <= q_in;
      out_ff <= out_in;
      if (reset) begin
         st_ff   <= ST_IDLE;
         act_ff  <= '0;
         idx_ff  <= '0;
         emit_ff <= 1'b1;
         ov_ff   <= 1'b0;
         dc_ff   <= 4'd0;
      end else begin
         st_ff   <= st_in;
         act_ff  <= act_in;
         idx_ff  <= idx_in;
         emit_ff <= emit_in;
         ov_ff   <= ov_in;
         dc_ff   <= (st_ff == ST_DIV) ? dc_in : 4'd0;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && !rsp.ready) |=> ov_ff && $stable(out_ff))
      else $error("result lost while stalled");
   a_oh: assert property (@(posedge clock) disable iff (reset) $onehot(st_ff))
      else $error("state not one-hot");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> st_ff == ST_IDLE)
      else $error("pop while busy");
   a_free: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_OUT && act_ff[idx_ff] && nl_ff <= 0 && !ov_in) |=> !act_ff[$past(idx_ff)])
      else $error("expired slot kept");
   a_emit: assert property (@(posedge clock) disable iff (reset) emit_ff == (st_ff == ST_IDLE))
      else $error("idle mark out of step");
endmodule
`default_nettype wire

FILE: sv/particle_pool_update.sv
// Top level of the particle pool.
// An emit finds the lowest free slot at once from the active map and registers its single
// result. A tick walks the slots one at a time; each slot goes through store read, multiply,
// saturate, an eight-step restoring fade divider and result, stalling while a result is held.
// Requests queue in a two-entry front buffer. The user must write time_step through the csr
// channel only while the block is idle; the block itself does not enforce this.
`default_nettype none
module particle_pool_update import ppu_pkg::*; #(
   parameter int PoolSize = PoolSizeDefault
) (
   input wire logic  clock,
   input wire logic  reset,
   ppu_req_if.sink   req,
   ppu_rsp_if.source rsp,
   ppu_csr_if.sink   csr
);
   logic [StepW-1:0] step_ff;
   logic             q_valid, q_pop;
   req_type          q_data;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) step_ff <= StepReset;
      else if (csr.valid) step_ff <= csr.data;
   end

   ppu_front u_front (.clock, .reset, .req, .q_valid, .q_data, .q_pop);
   ppu_back #(.PoolSize(PoolSize)) u_back (
      .clock, .reset, .step(step_ff), .q_valid, .q_data, .q_pop, .rsp);
endmodule
`default_nettype wire
